// ===== sv/bwi_pkg.sv =====
package bwi_pkg;

    localparam int FRAC_BITS   = 11;
    localparam int SAMPLE_BITS = 8;
    localparam int LANES       = 4;
    localparam int ROW_BITS    = 32;
    localparam int CW          = 32;

    localparam int CUBIC_STAGES = 4;
    localparam int PIPE_STAGES  = 2 * CUBIC_STAGES + 1;

    typedef logic signed [CW-1:0]        coef_t;
    typedef logic [FRAC_BITS-1:0]        frac_t;
    typedef logic [SAMPLE_BITS-1:0]      sample_t;
    typedef logic [CUBIC_STAGES-1:0]     stage_en_t;

    localparam coef_t HALF_UNIT = coef_t'(1) <<< (FRAC_BITS - 1);

endpackage

// ===== sv/bwi_cubic.sv =====
module bwi_cubic (
    input  logic                clk,
    input  bwi_pkg::stage_en_t  en,
    input  bwi_pkg::coef_t      a,
    input  bwi_pkg::coef_t      b,
    input  bwi_pkg::coef_t      c,
    input  bwi_pkg::coef_t      d,
    input  bwi_pkg::frac_t      t,
    output bwi_pkg::coef_t      r
);

    function automatic bwi_pkg::coef_t fx_mul(bwi_pkg::frac_t f, bwi_pkg::coef_t h);
        logic signed [bwi_pkg::CW+bwi_pkg::FRAC_BITS:0] p;
        p = $signed({1'b0, f}) * h;
        return bwi_pkg::coef_t'(p >>> bwi_pkg::FRAC_BITS);
    endfunction

    function automatic bwi_pkg::coef_t half_tz(bwi_pkg::coef_t h);
        bwi_pkg::coef_t adj;
        adj = h + bwi_pkg::coef_t'({1'b0, h[bwi_pkg::CW-1]});
        return adj >>> 1;
    endfunction

    bwi_pkg::coef_t k0_reg, k1_reg, k2_reg, k3_reg;
    bwi_pkg::frac_t t0_reg, t1_reg, t2_reg;
    bwi_pkg::coef_t k0_1_reg, k1_1_reg, k0_2_reg;
    bwi_pkg::coef_t h1_reg, h2_reg, r_reg;
    bwi_pkg::coef_t bc_diff;

    assign bc_diff = b - c;

    // coefficient stage
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            k0_reg <= b <<< 1;
            k1_reg <= c - a;
            k2_reg <= (a <<< 1) - (b + (b <<< 2)) + (c <<< 2) - d;
            k3_reg <= d - a + (bc_diff <<< 1) + bc_diff;
            t0_reg <= t;
        end
    end

    // horner steps
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            h1_reg   <= k2_reg + fx_mul(t0_reg, k3_reg);
            k0_1_reg <= k0_reg;
            k1_1_reg <= k1_reg;
            t1_reg   <= t0_reg;
        end
        if (en[2])
        begin
            h2_reg   <= k1_1_reg + fx_mul(t1_reg, h1_reg);
            k0_2_reg <= k0_1_reg;
            t2_reg   <= t1_reg;
        end
        if (en[3])
        begin
            r_reg <= half_tz(k0_2_reg + fx_mul(t2_reg, h2_reg));
        end
    end

    assign r = r_reg;

endmodule

// ===== sv/bwi_round.sv =====
module bwi_round (
    input  logic              clk,
    input  logic              en,
    input  bwi_pkg::coef_t    v,
    output bwi_pkg::sample_t  pixel
);

    localparam bwi_pkg::coef_t SAT_MAX = (bwi_pkg::coef_t'(1) <<< bwi_pkg::SAMPLE_BITS) - 1;

    bwi_pkg::sample_t pixel_reg, pixel_next;

    always_comb
    begin
        bwi_pkg::coef_t q;
        q = (v + bwi_pkg::HALF_UNIT) >>> bwi_pkg::FRAC_BITS;
        if (q < 0)
        begin
            pixel_next = '0;
        end
        else if (q > SAT_MAX)
        begin
            pixel_next = '1;
        end
        else
        begin
            pixel_next = q[bwi_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// ===== sv/bicubic_window_interpolator.sv =====
// bicubic window interpolator
// input channel: in_valid / in_ready carry one beat per 4x4 window, given as
//   row_zero..row_three (four 8-bit samples each, leftmost in the low byte)
//   plus x_fraction and y_fraction in Q11
// output channel: out_valid / out_ready carry one beat per window, out_pixel
//   being the rounded, saturated Catmull-Rom result
// four row lanes run the horizontal cubic side by side; a fifth cubic unit
//   merges the row results with the vertical fraction, then a round stage
// the input beat passes nine register stages on its way to the output beat:
//   two 4-stage cubic pipelines (coefficients, then three multiply steps)
//   and the output register, the first loaded by the input beat
// throughput: one window per cycle while the receiver takes every beat
// a stalled receiver holds the output register; earlier stages keep filling
//   bubbles, and in_ready drops only when all 9 stages hold a beat
// reset clears all stage valid bits; the pipeline comes out of reset empty
//   with in_ready high
module bicubic_window_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bwi_pkg::ROW_BITS-1:0]  row_zero,
    input  logic [bwi_pkg::ROW_BITS-1:0]  row_one,
    input  logic [bwi_pkg::ROW_BITS-1:0]  row_two,
    input  logic [bwi_pkg::ROW_BITS-1:0]  row_three,
    input  bwi_pkg::frac_t                x_fraction,
    input  bwi_pkg::frac_t                y_fraction,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bwi_pkg::sample_t              out_pixel
);

    localparam int NS = bwi_pkg::PIPE_STAGES;
    localparam int CS = bwi_pkg::CUBIC_STAGES;

    logic [NS-1:0] valid_reg, valid_next, adv;
    logic [bwi_pkg::ROW_BITS-1:0] rows [bwi_pkg::LANES];
    bwi_pkg::coef_t row_res [bwi_pkg::LANES];
    bwi_pkg::frac_t y_pipe_reg [CS];
    bwi_pkg::coef_t vert_res;

    assign rows[0] = row_zero;
    assign rows[1] = row_one;
    assign rows[2] = row_two;
    assign rows[3] = row_three;

    // per-stage advance, bubbles collapse under a stalled output
    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NS-1];

    // horizontal lanes
    for (genvar g = 0; g < bwi_pkg::LANES; g++)
    begin : g_row
        bwi_pkg::coef_t tap [bwi_pkg::LANES];
        for (genvar k = 0; k < bwi_pkg::LANES; k++)
        begin : g_tap
            assign tap[k] = bwi_pkg::coef_t'({rows[g][k*bwi_pkg::SAMPLE_BITS +: bwi_pkg::SAMPLE_BITS],
                                              {bwi_pkg::FRAC_BITS{1'b0}}});
        end
        bwi_cubic u_row (
            .clk (clk),
            .en  (adv[CS-1:0]),
            .a   (tap[0]),
            .b   (tap[1]),
            .c   (tap[2]),
            .d   (tap[3]),
            .t   (x_fraction),
            .r   (row_res[g])
        );
    end

    // vertical fraction follows the row lanes
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            y_pipe_reg[0] <= y_fraction;
        end
        for (int i = 1; i < CS; i++)
        begin
            if (adv[i])
            begin
                y_pipe_reg[i] <= y_pipe_reg[i-1];
            end
        end
    end

    // merge of the row results
    bwi_cubic u_vert (
        .clk (clk),
        .en  (adv[2*CS-1:CS]),
        .a   (row_res[0]),
        .b   (row_res[1]),
        .c   (row_res[2]),
        .d   (row_res[3]),
        .t   (y_pipe_reg[CS-1]),
        .r   (vert_res)
    );

    bwi_round u_round (
        .clk   (clk),
        .en    (adv[NS-1]),
        .v     (vert_res),
        .pixel (out_pixel)
    );

`ifndef NO_ASSERTIONS
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("in_ready low with a bubble in the pipeline");

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted beat lost at first stage");

    a_merge_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[CS] && !adv[CS] |=> valid_reg[CS])
        else $error("stalled merge stage dropped its beat");

    a_beat_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[CS-1] && adv[CS] |=> valid_reg[CS])
        else $error("row results not handed to merge stage");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    localparam int RANDOM_WINDOWS = 500;
    localparam int QUIET_TAIL     = 60;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;
    localparam longint PIXEL_MAX  = (longint'(1) <<< bwi_pkg::SAMPLE_BITS) - 1;

    typedef struct packed {
        logic                                             drain_mark;
        logic [bwi_pkg::LANES-1:0][bwi_pkg::ROW_BITS-1:0] rows;
        bwi_pkg::frac_t                                   fx;
        bwi_pkg::frac_t                                   fy;
    } window_t;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic                         in_ready;
    logic [bwi_pkg::ROW_BITS-1:0] row_zero   = '0;
    logic [bwi_pkg::ROW_BITS-1:0] row_one    = '0;
    logic [bwi_pkg::ROW_BITS-1:0] row_two    = '0;
    logic [bwi_pkg::ROW_BITS-1:0] row_three  = '0;
    bwi_pkg::frac_t               x_fraction = '0;
    bwi_pkg::frac_t               y_fraction = '0;
    logic                         out_valid;
    logic                         out_ready  = 1'b0;
    bwi_pkg::sample_t             out_pixel;

    window_t          windows_to_send[$];
    bwi_pkg::sample_t pending_pixels[$];
    window_t          next_window;
    bwi_pkg::sample_t want_pixel;
    int      windows_issued = 0;
    int      windows_taken  = 0;
    int      errors         = 0;
    int      cycles         = 0;
    int      send_gap       = 0;
    int      send_calm      = 0;
    int      recv_stall     = 0;
    int      recv_calm      = 0;

    bicubic_window_interpolator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .row_zero   (row_zero),
        .row_one    (row_one),
        .row_two    (row_two),
        .row_three  (row_three),
        .x_fraction (x_fraction),
        .y_fraction (y_fraction),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_pixel  (out_pixel)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // horner form, products floored by the arithmetic shift
    function automatic longint catmull_rom(longint a, longint b, longint c, longint d,
                                           longint t);
        longint h;
        h = (2 * a - 5 * b + 4 * c - d)
            + ((t * (-a + 3 * b - 3 * c + d)) >>> bwi_pkg::FRAC_BITS);
        h = (c - a) + ((t * h) >>> bwi_pkg::FRAC_BITS);
        h = 2 * b + ((t * h) >>> bwi_pkg::FRAC_BITS);
        return h / 2;
    endfunction

    function automatic bwi_pkg::sample_t bicubic_pixel(
        logic [bwi_pkg::LANES-1:0][bwi_pkg::ROW_BITS-1:0] rows,
        bwi_pkg::frac_t fx, bwi_pkg::frac_t fy);
        longint taps [bwi_pkg::LANES];
        longint merged [bwi_pkg::LANES];
        longint v;
        int     r;
        int     k;
        for (r = 0; r < bwi_pkg::LANES; r++)
        begin
            for (k = 0; k < bwi_pkg::LANES; k++)
            begin
                taps[k] = longint'(rows[r][k*bwi_pkg::SAMPLE_BITS +: bwi_pkg::SAMPLE_BITS])
                          <<< bwi_pkg::FRAC_BITS;
            end
            merged[r] = catmull_rom(taps[0], taps[1], taps[2], taps[3], longint'(fx));
        end
        v = catmull_rom(merged[0], merged[1], merged[2], merged[3], longint'(fy));
        v = (v + (longint'(1) <<< (bwi_pkg::FRAC_BITS - 1))) >>> bwi_pkg::FRAC_BITS;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > PIXEL_MAX)
        begin
            v = PIXEL_MAX;
        end
        return bwi_pkg::sample_t'(v);
    endfunction

    task automatic queue_window(logic [bwi_pkg::ROW_BITS-1:0] r0,
                                logic [bwi_pkg::ROW_BITS-1:0] r1,
                                logic [bwi_pkg::ROW_BITS-1:0] r2,
                                logic [bwi_pkg::ROW_BITS-1:0] r3,
                                int fx, int fy, bit drain_mark);
        window_t w;
        w.drain_mark = drain_mark;
        w.rows       = {r3, r2, r1, r0};
        w.fx         = bwi_pkg::frac_t'(fx);
        w.fy         = bwi_pkg::frac_t'(fy);
        windows_to_send.push_back(w);
    endtask

    function automatic logic [bwi_pkg::ROW_BITS-1:0] random_row(int unsigned flavor,
                                                                int base);
        logic [bwi_pkg::ROW_BITS-1:0] row;
        int                           k;
        int                           s;
        row = $urandom;
        for (k = 0; k < bwi_pkg::LANES; k++)
        begin
            case (flavor)
                1: s = base + $urandom_range(0, 32) - 16;
                2: s = ($urandom_range(0, 1) == 1) ? 255 : 0;
                3: s = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                   : $urandom_range(0, 255);
                default: s = int'(row[k*bwi_pkg::SAMPLE_BITS +: bwi_pkg::SAMPLE_BITS]);
            endcase
            if (s < 0)
            begin
                s = 0;
            end
            if (s > 255)
            begin
                s = 255;
            end
            row[k*bwi_pkg::SAMPLE_BITS +: bwi_pkg::SAMPLE_BITS] = bwi_pkg::sample_t'(s);
        end
        return row;
    endfunction

    function automatic int random_fraction();
        if ($urandom_range(0, 7) == 0)
        begin
            return ($urandom_range(0, 1) == 1) ? 2047 : 0;
        end
        return $urandom_range(0, 2047);
    endfunction

    // stimulus and end of run
    initial
    begin : stimulus
        int          i;
        int unsigned flavor;
        int          base;
        queue_window(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 0, 0, 0);
        queue_window(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 2047, 2047, 0);
        queue_window(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0);
        queue_window(32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 1024, 0, 0);
        queue_window(32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 1024, 2047, 0);
        queue_window(32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 300, 0, 0);
        queue_window(32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 1750, 0, 0);
        queue_window(32'h00FF0000, 32'h00FF0000, 32'h00FF0000, 32'h00FF0000, 2047, 0, 0);
        queue_window(32'hFF00FFFF, 32'hFF00FFFF, 32'hFF00FFFF, 32'hFF00FFFF, 1024, 1024, 0);
        queue_window(32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 1024, 1024, 0);
        queue_window(32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00, 1024, 1024, 0);
        queue_window(32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1024, 0);
        queue_window(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 0, 1024, 0);
        queue_window(32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 300, 0);
        queue_window(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 0, 1750, 0);
        queue_window(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 1, 2046, 0);
        queue_window(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 2046, 1, 0);
        queue_window(32'hFF0000FF, 32'h00FFFF00, 32'h00FFFF00, 32'hFF0000FF, 2047, 2047, 0);
        queue_window(32'h00FFFF00, 32'hFF0000FF, 32'hFF0000FF, 32'h00FFFF00, 1024, 2047, 0);
        queue_window(32'h403F2010, 32'h504F3020, 32'h605F4030, 32'h706F5040, 512, 1536, 0);
        queue_window(32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9, 32'h87654321, 2047, 0, 0);
        queue_window('0, '0, '0, '0, 0, 0, 1);
        for (i = 0; i < RANDOM_WINDOWS; i++)
        begin
            if (i == RANDOM_WINDOWS / 2)
            begin
                queue_window('0, '0, '0, '0, 0, 0, 1);
            end
            flavor = $urandom_range(0, 3);
            base   = $urandom_range(0, 255);
            queue_window(random_row(flavor, base), random_row(flavor, base),
                         random_row(flavor, base), random_row(flavor, base),
                         random_fraction(), random_fraction(), 0);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (windows_to_send.size() != 0 || windows_taken != windows_issued)
        begin
            @(posedge clk);
        end
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * bwi_pkg::PIPE_STAGES) @(posedge clk);
        if (errors == 0 && pending_pixels.size() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // window driver
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && windows_taken != windows_issued))
        begin
            if (send_calm > 0)
            begin
                send_calm--;
            end
            else if (send_gap == 0 && $urandom_range(0, 39) == 0)
            begin
                send_calm = $urandom_range(20, 80);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (windows_to_send.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (windows_to_send[0].drain_mark)
            begin
                in_valid <= 1'b0;
                if (pending_pixels.size() == 0 && windows_taken == windows_issued)
                begin
                    void'(windows_to_send.pop_front());
                end
            end
            else if (windows_to_send.size() > QUIET_TAIL && send_calm == 0
                     && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(1, 6) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                next_window = windows_to_send.pop_front();
                row_zero   <= next_window.rows[0];
                row_one    <= next_window.rows[1];
                row_two    <= next_window.rows[2];
                row_three  <= next_window.rows[3];
                x_fraction <= next_window.fx;
                y_fraction <= next_window.fy;
                in_valid   <= 1'b1;
                windows_issued++;
            end
        end
    end

    // pixel receiver backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_calm > 0)
            begin
                recv_calm--;
            end
            else if (recv_stall == 0 && $urandom_range(0, 39) == 0)
            begin
                recv_calm = $urandom_range(20, 80);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else if (windows_to_send.size() > QUIET_TAIL && recv_calm == 0
                     && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // predict on each window beat, check on each pixel beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("unexpected pixel beat: got %0d", out_pixel);
                    end
                end
                else
                begin
                    want_pixel = pending_pixels.pop_front();
                    if (out_pixel !== want_pixel)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("pixel mismatch: expected %0d, got %0d",
                                     want_pixel, out_pixel);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_pixels.push_back(bicubic_pixel({row_three, row_two, row_one, row_zero},
                                                       x_fraction, y_fraction));
                windows_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule
